// ===== rtl/core/fc16_pkg.sv =====
// ----------------------------------------------------------------------------
// fc16_pkg
// Shared types, constants and the byte-wide crc update for the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fc16_pkg;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  TERM_BYTE = 8'h0A;
  localparam logic [8:0]  COUNT_MAX = 9'd511;

  // header byte positions within a frame
  localparam logic [8:0] POS_MAGIC_LO = 9'd0;
  localparam logic [8:0] POS_MAGIC_HI = 9'd1;
  localparam logic [8:0] POS_VERSION  = 9'd2;
  localparam logic [8:0] POS_TYPE     = 9'd3;
  localparam logic [8:0] POS_LENGTH   = 9'd4;

  // bytes around the payload: magic, version, type, length, crc, terminator
  localparam logic [9:0] FRAME_OVERHEAD = 10'd8;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC_WORD   = 2'd0,
    REG_VERSION_BYTE = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic       frame_ok;
    logic [7:0] msg_type;
    logic [7:0] payload_len;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] magic_word;
    logic [7:0]  version_byte;
  } cfg_regs_t;

  // msb-first crc-16 update over one byte, eight shift steps
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fc16_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fc16_cfg_regs
// Configuration register file: expected magic and protocol version.
// ----------------------------------------------------------------------------
`default_nettype none

module fc16_cfg_regs
  import fc16_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]          wr_data,
  output cfg_regs_t                 regs
);

  cfg_regs_t regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAGIC_WORD:   regs_q.magic_word   <= wr_data[15:0];
        REG_VERSION_BYTE: regs_q.version_byte <= wr_data[7:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  assign regs = regs_q;

endmodule

`default_nettype wire

// ===== rtl/core/fc16_frame_track.sv =====
// ----------------------------------------------------------------------------
// fc16_frame_track
// Per-frame state: byte count, running crc, delay line and header checks.
// ----------------------------------------------------------------------------
`default_nettype none

module fc16_frame_track
  import fc16_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_beat_t  beat,
  input  wire cfg_regs_t cfg,
  output out_beat_t      result
);

  logic [8:0]  byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_bytes [3];
  logic [7:0]  held_bytes_next [3];
  logic [7:0]  magic_low, magic_low_next;
  logic        header_ok, header_ok_next;
  logic [7:0]  type_seen, type_seen_next;
  logic [7:0]  length_seen, length_seen_next;
  logic [15:0] rx_crc;
  logic        len_match;

  always_comb begin
    magic_low_next   = magic_low;
    header_ok_next   = header_ok;
    type_seen_next   = type_seen;
    length_seen_next = length_seen;

    if (byte_count == POS_MAGIC_LO) begin
      magic_low_next = beat.rx_byte;
    end else if (byte_count == POS_MAGIC_HI) begin
      if ({beat.rx_byte, magic_low} != cfg.magic_word) header_ok_next = 1'b0;
    end else if (byte_count == POS_VERSION) begin
      if (beat.rx_byte != cfg.version_byte) header_ok_next = 1'b0;
    end else if (byte_count == POS_TYPE) begin
      type_seen_next = beat.rx_byte;
    end else if (byte_count == POS_LENGTH) begin
      length_seen_next = beat.rx_byte;
    end

    // last three bytes of a frame never reach the crc
    running_crc_next = (byte_count >= POS_TYPE) ? crc16_feed(running_crc, held_bytes[0])
                                                : running_crc;
    held_bytes_next[0] = held_bytes[1];
    held_bytes_next[1] = held_bytes[2];
    held_bytes_next[2] = beat.rx_byte;

    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 9'd1 : byte_count;

    rx_crc    = {held_bytes_next[1], held_bytes_next[0]};
    len_match = ({1'b0, byte_count} + 10'd1) == ({2'b00, length_seen_next} + FRAME_OVERHEAD);

    result.frame_ok    = header_ok_next && len_match && (byte_count < COUNT_MAX)
                         && (beat.rx_byte == TERM_BYTE) && (rx_crc == running_crc_next);
    result.msg_type    = type_seen_next;
    result.payload_len = length_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && beat.frame_end)) begin
      byte_count  <= '0;
      running_crc <= CRC_INIT;
      held_bytes  <= '{default: 8'h00};
      magic_low   <= '0;
      header_ok   <= 1'b1;
      type_seen   <= '0;
      length_seen <= '0;
    end else if (step) begin
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
      held_bytes  <= held_bytes_next;
      magic_low   <= magic_low_next;
      header_ok   <= header_ok_next;
      type_seen   <= type_seen_next;
      length_seen <= length_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frame_checker_crc16_top.sv =====
// ----------------------------------------------------------------------------
// frame_checker_crc16_top
// Byte-serial frame checker with crc-16 (0x1021, init 0xFFFF, msb first).
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | beat
//   --------+-----------+------------------------+--------------------------
//   in      | sink      | in_valid / in_stall    | in_beat_t  (byte, end)
//   out     | source    | out_valid / out_stall  | out_beat_t (ok, type, len)
//   cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one byte per cycle sustained unless a finished result waits on a stalled out;
// a byte is registered, then runs through the frame tracker (one byte-wide crc step)
// a frame result is registered on out as its last byte leaves the input register
// in_stall rises only when the input register is full and a finished result
// still waits on a stalled output; non-final bytes never wait on out
// synchronous reset returns frame state to its start values and clears both
// config registers
// cfg writes are taken every cycle (cfg_ready is tied high)
// ----------------------------------------------------------------------------
`default_nettype none

module frame_checker_crc16_top
  import fc16_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input byte channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_beat_t             in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cfg_regs_t cfg;
  in_beat_t  s1_beat;
  logic      s1_valid;
  logic      fire;
  logic      in_take;
  out_beat_t result;

  // config register file
  assign cfg_ready = 1'b1;

  fc16_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  // a registered byte moves on unless it closes a frame whose result
  // cannot be written because the output register is still held
  assign fire     = s1_valid && (!s1_beat.frame_end || !out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_beat <= in_data;
    end
  end

  // frame state and checks
  fc16_frame_track u_track (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .beat   (s1_beat),
    .cfg    (cfg),
    .result (result)
  );

  // result register, loaded on the last byte of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1_beat.frame_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_beat.frame_end) begin
      out_data <= result;
    end
  end

  // checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_beat.frame_end) |=> out_valid)
    else $error("frame end did not produce a result");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(fire && s1_beat.frame_end)) |=> !out_valid)
    else $error("result delivered twice");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_beat.frame_end && out_valid))
    else $error("input stalled without a held result");

  a_nonfinal_flows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_beat.frame_end) |-> fire)
    else $error("non-final byte blocked");

endmodule

`default_nettype wire

// ===== tb/sv/frame_verdict_check.sv =====
// ----------------------------------------------------------------------------
// frame_verdict_check
// Watches the byte, result and register channels of the frame checker, keeps
// its own copy of the frame state and compares every result beat in order.
// ----------------------------------------------------------------------------
module frame_verdict_check
  import fc16_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_beat_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_beat_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fault_count,
  output int                   waiting_count,
  output int                   checked_count,
  output int                   good_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0] magic_reg;
  logic [7:0]  version_reg;

  // frame state
  logic [8:0]  byte_pos;
  logic [15:0] crc_acc;
  logic [7:0]  tail [3];
  logic [7:0]  magic_lo_seen;
  logic        hdr_good;
  logic [7:0]  type_byte;
  logic [7:0]  len_byte;

  out_beat_t   verdict_q [$];
  int          faults;
  int          checked;
  int          goods;

  // bit-serial form of the msb-first crc
  function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic clear_frame();
    byte_pos      = '0;
    crc_acc       = CRC_INIT;
    tail[0]       = '0;
    tail[1]       = '0;
    tail[2]       = '0;
    magic_lo_seen = '0;
    hdr_good      = 1'b1;
    type_byte     = '0;
    len_byte      = '0;
  endtask

  task automatic track_byte(input in_beat_t beat);
    logic [8:0]  pos;
    logic [9:0]  total;
    logic [15:0] crc_field;
    out_beat_t   want;
    pos = byte_pos;
    case (pos)
      POS_MAGIC_LO: magic_lo_seen = beat.rx_byte;
      POS_MAGIC_HI: begin
        if ({beat.rx_byte, magic_lo_seen} != magic_reg) hdr_good = 1'b0;
      end
      POS_VERSION: begin
        if (beat.rx_byte != version_reg) hdr_good = 1'b0;
      end
      POS_TYPE:   type_byte = beat.rx_byte;
      POS_LENGTH: len_byte  = beat.rx_byte;
      default: ;
    endcase
    // the crc lags three bytes so the crc field and terminator stay out
    if (pos >= POS_TYPE) crc_acc = crc_update(crc_acc, tail[0]);
    tail[0] = tail[1];
    tail[1] = tail[2];
    tail[2] = beat.rx_byte;
    if (byte_pos < COUNT_MAX) byte_pos = byte_pos + 9'd1;
    if (beat.frame_end) begin
      total     = 10'(pos) + 10'd1;
      crc_field = {tail[1], tail[0]};
      want.frame_ok = hdr_good && total >= FRAME_OVERHEAD && pos < COUNT_MAX &&
                      total == 10'(len_byte) + FRAME_OVERHEAD &&
                      beat.rx_byte == TERM_BYTE && crc_field == crc_acc;
      want.msg_type    = type_byte;
      want.payload_len = len_byte;
      verdict_q.push_back(want);
      clear_frame();
    end
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (verdict_q.size() == 0) begin
      faults++;
      $display("%0t: result beat with none expected, got ok=%0b type=%02h len=%02h",
               $time, got.frame_ok, got.msg_type, got.payload_len);
    end else begin
      want = verdict_q.pop_front();
      checked++;
      if (want.frame_ok) goods++;
      if (got.frame_ok !== want.frame_ok) begin
        faults++;
        $display("%0t: frame_ok mismatch, expected %0b, got %0b",
                 $time, want.frame_ok, got.frame_ok);
      end
      if (got.msg_type !== want.msg_type) begin
        faults++;
        $display("%0t: msg_type mismatch, expected %02h, got %02h",
                 $time, want.msg_type, got.msg_type);
      end
      if (got.payload_len !== want.payload_len) begin
        faults++;
        $display("%0t: payload_len mismatch, expected %02h, got %02h",
                 $time, want.payload_len, got.payload_len);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      magic_reg   = '0;
      version_reg = '0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC_WORD:   magic_reg   = cfg_data[15:0];
          REG_VERSION_BYTE: version_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) track_byte(in_data);
    end
    fault_count   <= faults;
    waiting_count <= verdict_q.size();
    checked_count <= checked;
    good_count    <= goods;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte streams into the crc-16 frame checker: well-formed
// frames with random content, frames broken in one field, short, overlong
// and noise frames, under several magic and version settings, with random
// gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fc16_pkg::*;

  // register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 50;    // random bytes per phase, at least; overlong frames are not counted

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  int fault_count;
  int waiting_count;
  int checked_count;
  int good_count;

  // frame under construction and the register values the frames are built for
  logic [7:0]  frame_bytes [$];
  logic [15:0] tx_crc;
  logic [15:0] cur_magic   = '0;
  logic [7:0]  cur_version = '0;

  // steady flags switch off idling on one side for a stretch
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;

  int bytes_sent    = 0;
  int frames_sent   = 0;
  int settings_used = 1;
  int stall_hold    = 0;

  frame_checker_crc16_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_verdict_check verdict_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fault_count   (fault_count),
    .waiting_count (waiting_count),
    .checked_count (checked_count),
    .good_count    (good_count)
  );

  always #5 clk = ~clk;

  // idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(15, 40);
  endfunction

  // crc used to build well-formed frames
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // result side: random stall runs and free runs
  always @(posedge clk) begin
    if (rst || sink_steady) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if ($urandom_range(0, 99) < 35) begin
      out_stall  <= 1'b1;
      stall_hold = pick_gap();
    end else begin
      out_stall  <= 1'b0;
      stall_hold = $urandom_range(0, 8);
    end
  end

  // one byte beat; valid stays high into the next beat when no gap follows
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, frame_end: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames_sent++;
  endtask

  // header and payload bytes go into the crc
  task automatic add_body(input logic [7:0] b);
    frame_bytes.push_back(b);
    tx_crc = crc_next(tx_crc, b);
  endtask

  // pay_n payload bytes; decl is what the length byte claims
  task automatic build_frame(input int pay_n, input logic [7:0] decl,
                             input logic [7:0] mtype);
    frame_bytes.delete();
    tx_crc = CRC_INIT;
    add_body(cur_magic[7:0]);
    add_body(cur_magic[15:8]);
    add_body(cur_version);
    add_body(mtype);
    add_body(decl);
    repeat (pay_n) add_body(8'($urandom()));
    frame_bytes.push_back(tx_crc[7:0]);
    frame_bytes.push_back(tx_crc[15:8]);
    frame_bytes.push_back(TERM_BYTE);
  endtask

  // stop sending and let every expected result come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (waiting_count == 0);
    // leave some margin after the last result has come out
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // only called with the block idle; upper data bits are junk on purpose
  task automatic set_regs(input logic [15:0] m, input logic [7:0] v);
    cfg_beat(REG_SPARE_2, $urandom());
    cfg_beat(REG_MAGIC_WORD, {16'($urandom()), m});
    cfg_beat(REG_VERSION_BYTE, {24'($urandom()), v});
    cfg_beat(REG_SPARE_3, $urandom());
    cfg_valid   <= 1'b0;
    cur_magic   = m;
    cur_version = v;
    settings_used++;
  endtask

  // mostly good frames with random content, the rest broken in one place or replaced by noise
  task automatic random_frame();
    int         pick;
    int         pay_n;
    logic [7:0] flip;
    pick  = $urandom_range(0, 99);
    pay_n = ($urandom_range(0, 99) < 4)  ? 255 :
            ($urandom_range(0, 99) < 10) ? $urandom_range(13, 64) :
                                           $urandom_range(0, 12);
    flip  = 8'($urandom_range(1, 255));
    build_frame(pay_n, 8'(pay_n), 8'($urandom()));
    if (pick < 55) begin
      // well formed
    end else if (pick < 60) begin
      frame_bytes[0] ^= flip;                          // magic low byte
    end else if (pick < 65) begin
      frame_bytes[1] ^= flip;                          // magic high byte
    end else if (pick < 69) begin
      frame_bytes[2] ^= flip;                          // version
    end else if (pick < 74) begin
      frame_bytes[frame_bytes.size() - 3 + $urandom_range(0, 1)] ^= flip;   // crc field
    end else if (pick < 78) begin
      frame_bytes[$urandom_range(3, frame_bytes.size() - 4)] ^= flip;      // covered byte
    end else if (pick < 82) begin
      frame_bytes[frame_bytes.size() - 1] ^= flip;     // terminator
    end else if (pick < 86) begin
      // length byte disagrees with the real size, crc still consistent
      build_frame(pay_n, 8'(pay_n) ^ flip, 8'($urandom()));
    end else if (pick < 91) begin
      // cut short, between one and seven bytes missing
      repeat ($urandom_range(1, 7)) frame_bytes.delete(frame_bytes.size() - 1);
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom()));
    end else begin
      // line noise
      frame_bytes.delete();
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom()));
    end
    send_frame();
  endtask

  initial begin : stimulus
    int start;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: good minimum frame under the reset register values
    build_frame(0, 8'd0, 8'h00);
    send_frame();
    // a lone end byte, nothing of the header seen
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    // short frame that still carries type and length
    build_frame(3, 8'd3, 8'hA5);
    while (frame_bytes.size() > 5) frame_bytes.delete(frame_bytes.size() - 1);
    send_frame();
    drain();
    // all-ones registers, good frame with one payload byte
    set_regs(16'hFFFF, 8'hFF);
    build_frame(1, 8'd1, 8'hFF);
    send_frame();
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: set_regs(16'h0000, 8'h00);
        3: set_regs(16'hFFFF, 8'hFF);
        default: set_regs(16'($urandom()), 8'($urandom()));
      endcase

      // phase 1 runs with no idling on either side
      src_steady  = (phase == 1);
      sink_steady <= (phase == 1) || (phase == 2);

      // overlong frames: one past the longest legal size, one that
      // drives the byte counter into saturation
      if (phase == 1) begin
        build_frame(507, 8'(507), 8'($urandom()));
        send_frame();
      end else if (phase == 3) begin
        build_frame(262, 8'(262), 8'($urandom()));
        send_frame();
      end

      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        if (phase > 2) begin
          src_steady  = ($urandom_range(0, 7) == 0);
          sink_steady <= ($urandom_range(0, 9) == 0);
        end
        random_frame();
        // sometimes hold off until the block has emptied
        if ($urandom_range(0, 14) == 0) drain();
      end
      drain();
    end

    $display("run sent %0d bytes in %0d frames under %0d register settings",
             bytes_sent, frames_sent, settings_used);
    $display("compared %0d result beats, %0d of them good frames",
             checked_count, good_count);
    if (fault_count == 0 && waiting_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", waiting_count);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fc16_pkg.sv
rtl/core/fc16_cfg_regs.sv
rtl/core/fc16_frame_track.sv
rtl/core/frame_checker_crc16_top.sv
tb/sv/frame_verdict_check.sv
tb/sv/testbench.sv
